### hw/rtl/fdr_pkg.sv
// shared types, constants and helpers of the frame dirty-rectangle detector
// no dependencies
package fdr_pkg;

    localparam int COORD_BITS = 15;
    localparam int CFG_BITS   = 15;
    localparam int PIXEL_BITS = 32;
    localparam int IDX_BITS   = 8;
    localparam int DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 8'd1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] prev_pixel;
        logic [PIXEL_BITS-1:0] curr_pixel;
    } in_t;

    typedef struct packed {
        coord_t rect_x;
        coord_t rect_y;
        coord_t rect_width;
        coord_t rect_height;
        logic   has_rect;
        logic   overflow;
        logic   frame_last;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic set_ovf;
        logic wr_merge;
        logic wr_new;
        logic emit;
        logic swap;
        logic row_step;
        logic final_out;
        logic frame_clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic merge_req;
        logic row_end;
        logic frame_end;
        logic next_full;
        logic idx_end;
        logic cur_valid;
        logic overlap;
        logic emit_ok;
        logic out_free;
    } sts_t;

    function automatic out_t make_out(rect_t r, logic has, logic ovf, logic last);
        out_t o;
        o.rect_x      = has ? r.x : '0;
        o.rect_y      = has ? r.y : '0;
        o.rect_width  = has ? r.w : '0;
        o.rect_height = has ? r.h : '0;
        o.has_rect    = has;
        o.overflow    = ovf;
        o.frame_last  = last;
        return o;
    endfunction

endpackage

### hw/rtl/frame_dirty_rectangles.sv
// top level of the frame dirty-rectangle detector
// depends on fdr_pkg, fdr_ctrl, fdr_datapath (and through it fdr_ram)
//
// usage
//   s_ channel: one request per pixel pair (previous and current frame word),
//   raster order. a pixel is dirty when the two words differ; runs of dirty
//   pixels grow rectangles from row to row.
//   m_ channel: one request per finished rectangle. at row end the rectangles
//   that no run continued come out; at frame end every open rectangle follows,
//   the last one flagged frame_last (or an empty marker when there is none).
//   cfg channel: register 0 is frame_width, register 1 frame_height; always
//   ready. the user writes it only while the block is idle; not enforced.
// sequence
//   a pixel with no finished run passes through the accept and start states.
//   closing a run adds a search of the prior-row table, one table entry
//   read per step through the ram read port. a row end adds a pass over the
//   table with an extra step per emitted rectangle, and a frame end a second
//   pass and the final request.
// reset and stall
//   aresetn (synchronous, low) clears counters, valid bits and flags; no
//   clearing pass is needed. a stalled m_ready holds the output register;
//   the emission pass waits on it, and new pixels wait until the pass ends.
module frame_dirty_rectangles #(
    parameter int MAX_RECTS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fdr_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fdr_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdr_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [fdr_pkg::DATA_BITS-1:0] cfg_data
);

    fdr_pkg::cmd_t cmd;
    fdr_pkg::sts_t sts;

    // config writes are taken at any time
    assign cfg_ready = 1'b1;

    // sequencer
    fdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // tables, counters and result registers
    fdr_datapath #(
        .MAX_RECTS (MAX_RECTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hw/rtl/fdr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module fdr_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/fdr_ctrl.sv
// sequencer of the dirty-rectangle detector: merge search, emission passes, frame end
// depends on fdr_pkg
module fdr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fdr_pkg::sts_t sts,
    output fdr_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MSCAN,
        ST_MCMP,
        ST_ESCAN,
        ST_EDATA,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (sts.merge_req && !sts.next_full) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_MSCAN;
                end else begin
                    cmd.set_ovf = sts.merge_req;
                    if (sts.row_end) begin
                        cmd.idx_clr = 1'b1;
                        pass_next   = 1'b0;
                        state_next  = ST_ESCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MSCAN: begin
                if (sts.idx_end) begin
                    cmd.wr_new = 1'b1;
                    if (sts.row_end) begin
                        cmd.idx_clr = 1'b1;
                        pass_next   = 1'b0;
                        state_next  = ST_ESCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (sts.cur_valid) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_MCMP;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_MCMP: begin
                if (sts.overlap) begin
                    cmd.wr_merge = 1'b1;
                    if (sts.row_end) begin
                        cmd.idx_clr = 1'b1;
                        pass_next   = 1'b0;
                        state_next  = ST_ESCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_MSCAN;
                end
            end
            ST_ESCAN: begin
                if (sts.idx_end) begin
                    if (!pass_reg) begin
                        cmd.swap = 1'b1;
                        if (sts.frame_end) begin
                            cmd.idx_clr = 1'b1;
                            pass_next   = 1'b1;
                        end else begin
                            cmd.row_step = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_FINAL;
                    end
                end else if (sts.cur_valid) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_EDATA;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_EDATA: begin
                if (sts.emit_ok) begin
                    cmd.emit    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_ESCAN;
                end
            end
            ST_FINAL: begin
                if (sts.out_free) begin
                    cmd.final_out   = 1'b1;
                    cmd.frame_clear = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

### hw/rtl/fdr_datapath.sv
// datapath: counters, run tracking, ping-pong rectangle tables, result registers
// depends on fdr_pkg and fdr_ram
module fdr_datapath #(
    parameter int MAX_RECTS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fdr_pkg::cmd_t                   cmd,
    output fdr_pkg::sts_t                   sts,
    input  fdr_pkg::in_t                    s_data,
    input  logic                            cfg_valid,
    input  logic [fdr_pkg::IDX_BITS-1:0]    cfg_index,
    input  logic [fdr_pkg::DATA_BITS-1:0]   cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fdr_pkg::out_t                   m_data
);

    localparam int CB = fdr_pkg::COORD_BITS;
    localparam int AW = $clog2(MAX_RECTS);
    localparam int IW = $clog2(MAX_RECTS + 1);
    localparam int RW = $bits(fdr_pkg::rect_t);

    logic [fdr_pkg::CFG_BITS-1:0] frame_width_reg, frame_height_reg;
    fdr_pkg::coord_t col_reg, row_reg, run_start_reg, sx_reg;
    logic            run_open_reg;
    logic [CB:0]     ex_reg;
    logic            merge_req_reg, row_end_reg, frame_end_reg;
    logic [IW-1:0]   idx_reg, count_reg;
    logic [MAX_RECTS-1:0] valid_reg, valid_next, thermo;
    logic            sel_reg, ovf_reg;
    logic            pend_valid_reg;
    fdr_pkg::rect_t  pend_reg;
    logic            m_valid_reg;
    fdr_pkg::out_t   m_data_reg;

    // step decode at accept
    logic        dirty, row_end, frame_end, run_close;
    logic [CB:0] col_inc, row_inc;

    assign dirty     = (s_data.prev_pixel != s_data.curr_pixel);
    assign col_inc   = {1'b0, col_reg} + (CB+1)'(1);
    assign row_inc   = {1'b0, row_reg} + (CB+1)'(1);
    assign row_end   = (col_inc >= (CB+1)'(frame_width_reg));
    assign frame_end = row_end && (row_inc >= (CB+1)'(frame_height_reg));
    assign run_close = !dirty && run_open_reg;

    // table banks
    logic [RW-1:0]   rdata_bank [2];
    fdr_pkg::rect_t  rd_rect, merged, fresh, wr_rect;
    logic            wr_en;
    logic [CB:0]     rend, ne, merged_diff, fresh_diff, sx_ext;
    fdr_pkg::coord_t nx;

    assign rd_rect = fdr_pkg::rect_t'(rdata_bank[sel_reg]);
    assign sx_ext  = {1'b0, sx_reg};
    assign rend    = {1'b0, rd_rect.x} + {1'b0, rd_rect.w};
    assign nx      = (sx_reg < rd_rect.x) ? sx_reg : rd_rect.x;
    assign ne      = (ex_reg > rend) ? ex_reg : rend;
    assign merged_diff = ne - {1'b0, nx};
    assign fresh_diff  = ex_reg - sx_ext;

    always_comb begin
        merged.x = nx;
        merged.w = merged_diff[CB-1:0];
        merged.y = rd_rect.y;
        merged.h = (rd_rect.h == '1) ? rd_rect.h : rd_rect.h + CB'(1);
        fresh.x  = sx_reg;
        fresh.y  = row_reg;
        fresh.w  = fresh_diff[CB-1:0];
        fresh.h  = CB'(1);
    end

    assign wr_en   = cmd.wr_merge || cmd.wr_new;
    assign wr_rect = cmd.wr_merge ? merged : fresh;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        fdr_ram #(
            .WIDTH (RW),
            .DEPTH (MAX_RECTS)
        ) u_ram (
            .aclk  (aclk),
            .we    (wr_en && (sel_reg != 1'(b))),
            .waddr (count_reg[AW-1:0]),
            .wdata (wr_rect),
            .re    (cmd.rd_en && (sel_reg == 1'(b))),
            .raddr (idx_reg[AW-1:0]),
            .rdata (rdata_bank[b])
        );
    end

    // status
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        sts.merge_req = merge_req_reg;
        sts.row_end   = row_end_reg;
        sts.frame_end = frame_end_reg;
        sts.next_full = (count_reg == IW'(MAX_RECTS));
        sts.idx_end   = (idx_reg == IW'(MAX_RECTS));
        sts.cur_valid = !sts.idx_end && valid_reg[idx_reg[AW-1:0]];
        sts.overlap   = (sx_ext < rend) && (ex_reg > {1'b0, rd_rect.x});
        sts.emit_ok   = frame_end_reg ? (!pend_valid_reg || out_free) : out_free;
        sts.out_free  = out_free;
    end

    // valid bits of the open bank
    always_comb begin
        for (int i = 0; i < MAX_RECTS; i++) begin
            thermo[i] = (IW'(i) < count_reg);
        end
        valid_next = valid_reg;
        if (cmd.wr_merge || cmd.emit) begin
            valid_next[idx_reg[AW-1:0]] = 1'b0;
        end
        if (cmd.swap) begin
            valid_next = thermo;
        end
        if (cmd.frame_clear) begin
            valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= fdr_pkg::CFG_BITS'(1);
            frame_height_reg <= fdr_pkg::CFG_BITS'(1);
            col_reg          <= '0;
            row_reg          <= '0;
            run_start_reg    <= '0;
            run_open_reg     <= 1'b0;
            merge_req_reg    <= 1'b0;
            row_end_reg      <= 1'b0;
            frame_end_reg    <= 1'b0;
            idx_reg          <= '0;
            count_reg        <= '0;
            valid_reg        <= '0;
            sel_reg          <= 1'b0;
            ovf_reg          <= 1'b0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == fdr_pkg::REG_FRAME_WIDTH) begin
                    frame_width_reg <= cfg_data[fdr_pkg::CFG_BITS-1:0];
                end else if (cfg_index == fdr_pkg::REG_FRAME_HEIGHT) begin
                    frame_height_reg <= cfg_data[fdr_pkg::CFG_BITS-1:0];
                end
            end

            if (cmd.accept) begin
                merge_req_reg <= run_close || (row_end && (dirty || run_open_reg));
                row_end_reg   <= row_end;
                frame_end_reg <= frame_end;
                run_open_reg  <= dirty && !row_end;
                if (dirty && !run_open_reg) begin
                    run_start_reg <= col_reg;
                    sx_reg        <= col_reg;
                end else begin
                    sx_reg        <= run_start_reg;
                end
                ex_reg  <= run_close ? {1'b0, col_reg} : col_inc;
                col_reg <= row_end ? '0 : col_inc[CB-1:0];
            end

            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IW'(1);
            end

            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end

            valid_reg <= valid_next;

            if (wr_en) begin
                count_reg <= count_reg + IW'(1);
            end
            if (cmd.swap) begin
                sel_reg   <= !sel_reg;
                count_reg <= '0;
            end

            if (cmd.row_step) begin
                row_reg <= row_inc[CB-1:0];
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cmd.emit) begin
                if (!frame_end_reg) begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= fdr_pkg::make_out(rd_rect, 1'b1, ovf_reg, 1'b0);
                end else begin
                    if (pend_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= fdr_pkg::make_out(pend_reg, 1'b1, ovf_reg, 1'b0);
                    end
                    pend_valid_reg <= 1'b1;
                    pend_reg       <= rd_rect;
                end
            end

            if (cmd.final_out) begin
                m_valid_reg    <= 1'b1;
                m_data_reg     <= fdr_pkg::make_out(pend_reg, pend_valid_reg, ovf_reg, 1'b1);
                pend_valid_reg <= 1'b0;
            end

            if (cmd.frame_clear) begin
                row_reg       <= '0;
                run_start_reg <= '0;
                ovf_reg       <= 1'b0;
                count_reg     <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/fdr_checker.sv
// port-level checks of the frame dirty-rectangle detector, bound to the top level
// depends on fdr_pkg
module fdr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input fdr_pkg::in_t                  s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input fdr_pkg::out_t                 m_data,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [fdr_pkg::IDX_BITS-1:0]  cfg_index,
    input logic [fdr_pkg::DATA_BITS-1:0] cfg_data
);

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // stalled request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // an empty marker only closes a frame
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_rect |-> m_data.frame_last &&
            m_data.rect_width == '0 && m_data.rect_height == '0)
        else $error("bad empty marker");

    // every rectangle spans at least one row
    a_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_rect |-> m_data.rect_height != '0)
        else $error("rectangle of zero height");

endmodule

bind frame_dirty_rectangles fdr_checker u_fdr_checker (.*);

### dv/testbench.sv
// self-checking testbench for frame_dirty_rectangles: pixel-pair stimulus,
// an in-bench rectangle tracker that predicts every result, and idling phases
// depends on fdr_pkg and frame_dirty_rectangles
`timescale 1ns / 100ps

module testbench;

    localparam int TBL_DEPTH  = 32;
    localparam int CYCLE_MAX  = 3000000;
    localparam int DRAIN_WAIT = 200;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    fdr_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    fdr_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [fdr_pkg::IDX_BITS-1:0]  cfg_index = '0;
    logic [fdr_pkg::DATA_BITS-1:0] cfg_data = '0;

    frame_dirty_rectangles #(.MAX_RECTS(TBL_DEPTH)) dut (.*);

    // pixel pairs waiting for the driver, rectangles waiting for the dut
    fdr_pkg::in_t  pixel_q[$];
    fdr_pkg::out_t rect_q[$];
    int   mismatches = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_req = 1'b0;
    bit   pause_send = 1'b0;
    int   hold_left = 0;
    longint unsigned cycles = 0;

    // tracker state, mirrors the row/rectangle bookkeeping of the block
    int unsigned trk_width = 1, trk_height = 1;
    int unsigned col_pos, row_pos, run_from;
    bit    run_active;
    fdr_pkg::rect_t prior_rects[TBL_DEPTH];
    bit    prior_live[TBL_DEPTH];
    fdr_pkg::rect_t row_rects[TBL_DEPTH];
    int unsigned row_rect_cnt;
    bit    table_ovf;
    int    frame_results;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void add_pixel(fdr_pkg::in_t p);
        pixel_q.insert(pixel_q.size(), p);
    endfunction

    function automatic void clear_tracker();
        col_pos = 0; row_pos = 0; run_from = 0; run_active = 0;
        row_rect_cnt = 0; table_ovf = 0;
        for (int i = 0; i < TBL_DEPTH; i++) prior_live[i] = 0;
    endfunction

    function automatic void close_run(int unsigned sx, int unsigned ex);
        int unsigned rend, lo, hi;
        fdr_pkg::rect_t m;
        if (row_rect_cnt >= TBL_DEPTH) begin
            table_ovf = 1;
            return;
        end
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (prior_live[i]) begin
                rend = prior_rects[i].x + prior_rects[i].w;
                if (sx < rend && ex > prior_rects[i].x) begin
                    lo = (sx < prior_rects[i].x) ? sx : prior_rects[i].x;
                    hi = (ex > rend) ? ex : rend;
                    m.x = fdr_pkg::coord_t'(lo);
                    m.w = fdr_pkg::coord_t'(hi - lo);
                    m.y = prior_rects[i].y;
                    // height saturates at all ones
                    m.h = (&prior_rects[i].h) ? prior_rects[i].h
                                              : prior_rects[i].h + 1'b1;
                    prior_live[i] = 0;
                    row_rects[row_rect_cnt++] = m;
                    return;
                end
            end
        end
        m.x = fdr_pkg::coord_t'(sx);
        m.y = fdr_pkg::coord_t'(row_pos);
        m.w = fdr_pkg::coord_t'(ex - sx);
        m.h = fdr_pkg::coord_t'(1);
        row_rects[row_rect_cnt++] = m;
    endfunction

    function automatic void push_rect(fdr_pkg::rect_t r, bit has);
        fdr_pkg::out_t o;
        o.rect_x = has ? r.x : '0;
        o.rect_y = has ? r.y : '0;
        o.rect_width = has ? r.w : '0;
        o.rect_height = has ? r.h : '0;
        o.has_rect = has;
        o.overflow = table_ovf;
        o.frame_last = 1'b0;
        rect_q.insert(rect_q.size(), o);
        frame_results++;
    endfunction

    function automatic void flush_prior();
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (prior_live[i]) begin
                push_rect(prior_rects[i], 1'b1);
                prior_live[i] = 0;
            end
        end
    endfunction

    function automatic void track_pixel(fdr_pkg::in_t px);
        bit dirty, row_done, frame_done;
        dirty = px.prev_pixel != px.curr_pixel;
        row_done = col_pos + 1 >= trk_width;
        frame_done = row_done && (row_pos + 1 >= trk_height);
        if (dirty && !run_active) begin
            run_from = col_pos;
            run_active = 1;
        end else if (!dirty && run_active) begin
            close_run(run_from, col_pos);
            run_active = 0;
        end
        if (!row_done) begin
            col_pos = (col_pos + 1) & 32'h7fff;
            return;
        end
        if (run_active) begin
            close_run(run_from, col_pos + 1);
            run_active = 0;
        end
        frame_results = 0;
        flush_prior();
        for (int i = 0; i < TBL_DEPTH; i++) begin
            prior_live[i] = i < row_rect_cnt;
            if (i < row_rect_cnt) prior_rects[i] = row_rects[i];
        end
        row_rect_cnt = 0;
        col_pos = 0;
        if (!frame_done) begin
            row_pos = (row_pos + 1) & 32'h7fff;
            return;
        end
        flush_prior();
        // empty frame still produces one marker
        if (frame_results == 0) push_rect('0, 1'b0);
        rect_q[rect_q.size() - 1].frame_last = 1'b1;
        row_pos = 0;
        run_from = 0;
        table_ovf = 0;
    endfunction

    // driver: pixel requests from the queue, random idle cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pixel_q.size() > 0 && !pause_send && $urandom_range(99) >= idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pixel_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            hold_left <= 600;
        end else begin
            m_ready <= $urandom_range(99) >= stall_pct;
        end
    end

    // monitor: track accepted pixels, check accepted rectangles
    always @(posedge aclk) begin
        fdr_pkg::out_t want;
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) track_pixel(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (rect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected rectangle x=%0d y=%0d w=%0d h=%0d has=%0b",
                             m_data.rect_x, m_data.rect_y, m_data.rect_width,
                             m_data.rect_height, m_data.has_rect);
            end else begin
                want = rect_q.pop_front();
                if (m_data.rect_x !== want.rect_x || m_data.rect_y !== want.rect_y ||
                    m_data.rect_width !== want.rect_width ||
                    m_data.rect_height !== want.rect_height ||
                    m_data.has_rect !== want.has_rect || m_data.overflow !== want.overflow ||
                    m_data.frame_last !== want.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%0d y=%0d w=%0d h=%0d has=%0b ovf=%0b last=%0b %s",
                                 want.rect_x, want.rect_y, want.rect_width, want.rect_height,
                                 want.has_rect, want.overflow, want.frame_last,
                                 $sformatf("got x=%0d y=%0d w=%0d h=%0d has=%0b ovf=%0b last=%0b",
                                 m_data.rect_x, m_data.rect_y, m_data.rect_width,
                                 m_data.rect_height, m_data.has_rect, m_data.overflow,
                                 m_data.frame_last));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    // one pixel pair, dirty or clean, with random words
    function automatic fdr_pkg::in_t make_pixel(bit dirty);
        fdr_pkg::in_t p;
        p.prev_pixel = $urandom;
        p.curr_pixel = dirty ? p.prev_pixel ^ ($urandom | 32'h1 << $urandom_range(31))
                             : p.prev_pixel;
        return p;
    endfunction

    task automatic queue_frame(int w, int h, int dirty_pct);
        for (int i = 0; i < w * h; i++)
            add_pixel(make_pixel($urandom_range(99) < dirty_pct));
    endtask

    task automatic wait_drained();
        while (pixel_q.size() > 0 || s_valid || rect_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [fdr_pkg::IDX_BITS-1:0] idx, int unsigned value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[fdr_pkg::DATA_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == fdr_pkg::REG_FRAME_WIDTH) trk_width = value & 32'h7fff;
        else trk_height = value & 32'h7fff;
    endtask

    task automatic set_frame(int w, int h);
        wait_drained();
        write_reg(fdr_pkg::REG_FRAME_WIDTH, w);
        write_reg(fdr_pkg::REG_FRAME_HEIGHT, h);
    endtask

    initial begin
        int w, h, hh, sent;
        fdr_pkg::in_t p;
        clear_tracker();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: single pixel frames at the reset size, all-zero and all-one words
        p.prev_pixel = '0;  p.curr_pixel = '1;  add_pixel(p);
        p.prev_pixel = '1;  p.curr_pixel = '0;  add_pixel(p);
        p.prev_pixel = '1;  p.curr_pixel = '1;  add_pixel(p);
        p.prev_pixel = '0;  p.curr_pixel = '0;  add_pixel(p);
        set_frame(1, 1);
        queue_frame(1, 1, 100);

        // run touching both row ends, merge across rows, empty frame
        set_frame(4, 3);
        add_pixel(make_pixel(1)); add_pixel(make_pixel(0));
        add_pixel(make_pixel(0)); add_pixel(make_pixel(1));
        add_pixel(make_pixel(0)); add_pixel(make_pixel(1));
        add_pixel(make_pixel(1)); add_pixel(make_pixel(1));
        add_pixel(make_pixel(1)); add_pixel(make_pixel(0));
        add_pixel(make_pixel(0)); add_pixel(make_pixel(0));
        queue_frame(4, 3, 0);

        // table full: more alternating runs than table entries, two rows
        set_frame(74, 2);
        for (int i = 0; i < 148; i++) add_pixel(make_pixel(i % 2 == 0));

        // random frames over several idling phases
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 68) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 68) : 0;
            for (int f = 0; f < 4; f++) begin
                w = $urandom_range(12, 1);
                h = $urandom_range(5, 1);
                hh = (ph == 0 && f == 3) ? h + 8 : h;
                set_frame(w, hh);
                if (ph == 0 && f == 3) begin
                    // long receiver hold-off while pixels keep coming
                    queue_frame(w, hh, 50);
                    hold_req <= 1'b1;
                    @(posedge aclk);
                    hold_req <= 1'b0;
                end else if (ph == 1 && f == 2) begin
                    // sender pauses mid-frame until every rectangle is out
                    queue_frame(w, hh, 40);
                    repeat (w * hh) @(posedge aclk);
                    pause_send <= 1'b1;
                    wait (rect_q.size() == 0 && !s_valid);
                    @(posedge aclk);
                    pause_send <= 1'b0;
                end else begin
                    queue_frame(w, hh, $urandom_range(90, 5));
                end
                sent += w * hh;
            end
            if (ph == 3 && sent < 320) ph = 2;
        end

        // back to the smallest frame at the end
        set_frame(1, 1);
        queue_frame(1, 4, 50);
        wait_drained();
        if (mismatches == 0 && rect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_ram.sv
hw/rtl/fdr_ctrl.sv
hw/rtl/fdr_datapath.sv
hw/rtl/frame_dirty_rectangles.sv
hw/rtl/fdr_checker.sv
dv/testbench.sv
